@@ hdl/rse_pkg.sv @@
// rse_pkg: item types, control struct and GF(256) multiply for the RS encoder
// used by rse_cell and reed_solomon_ecc_encoder; no dependencies
`default_nettype none

package rse_pkg;

  localparam int ByteW = 8;
  localparam int EccCountW = 6;
  localparam logic [EccCountW-1:0] EccReset = 6'd7;
  localparam logic [ByteW-1:0] FieldPolyLow = 8'h1D;
  localparam logic [ByteW-1:0] Alpha = 8'h02;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] ecc_byte;
    logic             last_ecc;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic build;
    logic shift;
    logic load;
    logic pop;
  } ctrl_t;

  function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] a,
                                              input logic [ByteW-1:0] b);
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[ByteW-2:0], 1'b0} ^ (x[ByteW-1] ? FieldPolyLow : '0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

@@ hdl/reed_solomon_ecc_encoder.sv @@
// reed_solomon_ecc_encoder: systematic RS(GF(256), 0x11D) check codeword encoder
// built as a chain of rse_cell stages; depends on rse_pkg and rse_cell
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (data_byte, is_last)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (ecc_byte, last_ecc)
//   cfg     | input     | cfg_we_i                  | cfg_data_i (ecc_count)
//
// one data item per cycle while in_stall_o is low; the chain updates the whole remainder in parallel
// a last item moves the remainder into the output row; its n check items leave
// one per cycle while out_stall_i is low, and a following last item waits until that row has drained
// after reset or a cfg write the generator is built while the input is stalled
// an output stall holds the output row; data items keep flowing into the chain
`default_nettype none

module reed_solomon_ecc_encoder import rse_pkg::*; #(
  parameter int MAX_ECC = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [EccCountW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(MAX_ECC + 1);
  localparam int IdxW = (MAX_ECC > 1) ? $clog2(MAX_ECC) : 1;
  localparam logic [6:0] MaxEcc7 = 7'(MAX_ECC);

  logic [EccCountW-1:0] ecc_q, ecc_d;
  logic                 init_q, init_d;
  logic [CntW-1:0]      steps_q, steps_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ByteW-1:0]     root_q, root_d;

  logic [6:0]       ecc7;
  logic [6:0]       n7;
  logic [CntW-1:0]  n_eff;
  logic [IdxW-1:0]  top_idx;
  logic             building;
  logic             pop;
  logic             can_load;
  logic             accept;
  logic             load;
  logic [ByteW-1:0] fb;
  logic [ByteW-1:0] mul_b;
  ctrl_t            ctrl;

  logic [ByteW-1:0] gen_row [MAX_ECC];
  logic [ByteW-1:0] rem_row [MAX_ECC];
  logic [ByteW-1:0] out_row [MAX_ECC];

  assign ecc7 = {1'b0, ecc_q};
  always_comb begin
    if (ecc_q == '0) begin
      n7 = 7'd1;
    end else if (ecc7 > MaxEcc7) begin
      n7 = MaxEcc7;
    end else begin
      n7 = ecc7;
    end
  end
  assign n_eff   = n7[CntW-1:0];
  assign top_idx = IdxW'(n_eff - CntW'(1));

  assign building    = init_q || (steps_q != '0);
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign can_load    = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop);
  assign in_stall_o  = building || (in_data_i.is_last && !can_load);
  assign accept      = in_valid_i && !in_stall_o;
  assign load        = accept && in_data_i.is_last;

  assign fb    = in_data_i.data_byte ^ rem_row[top_idx];
  assign mul_b = building ? root_q : fb;

  assign ctrl.init  = init_q;
  assign ctrl.build = !init_q && (steps_q != '0);
  assign ctrl.shift = accept;
  assign ctrl.load  = load;
  assign ctrl.pop   = pop;

  for (genvar j = 0; j < MAX_ECC; j++) begin : g_cell
    logic [ByteW-1:0] gen_prev;
    logic [ByteW-1:0] rem_prev;
    logic [ByteW-1:0] out_prev;
    logic [ByteW-1:0] gen_init;
    if (j == 0) begin : g_head
      assign gen_prev = '0;
      assign rem_prev = '0;
      assign out_prev = '0;
      assign gen_init = 8'h01;
    end else begin : g_body
      assign gen_prev = gen_row[j-1];
      assign rem_prev = rem_row[j-1];
      assign out_prev = out_row[j-1];
      assign gen_init = '0;
    end
    rse_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .gen_init_i (gen_init),
      .mul_b_i    (mul_b),
      .gen_prev_i (gen_prev),
      .rem_prev_i (rem_prev),
      .out_prev_i (out_prev),
      .gen_o      (gen_row[j]),
      .rem_o      (rem_row[j]),
      .out_o      (out_row[j])
    );
  end

  assign out_data_o.ecc_byte = out_row[top_idx];
  assign out_data_o.last_ecc = (cnt_q == CntW'(1));

  always_comb begin
    ecc_d   = ecc_q;
    init_d  = init_q;
    steps_d = steps_q;
    cnt_d   = cnt_q;
    root_d  = root_q;
    if (cfg_we_i) begin
      ecc_d   = cfg_data_i;
      init_d  = 1'b1;
      steps_d = '0;
      cnt_d   = '0;
    end else begin
      if (init_q) begin
        init_d  = 1'b0;
        steps_d = n_eff;
        root_d  = 8'h01;
      end else if (steps_q != '0) begin
        steps_d = steps_q - CntW'(1);
        root_d  = gf_mul(root_q, Alpha);
      end
      if (load) begin
        cnt_d = n_eff;
      end else if (pop) begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q   <= EccReset;
      init_q  <= 1'b1;
      steps_q <= '0;
      cnt_q   <= '0;
    end else begin
      ecc_q   <= ecc_d;
      init_q  <= init_d;
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

`ifndef ASSERT_OFF
  a_no_output_while_building: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> !building)
    else $error("check items pending while generator is being built");

  a_load_sets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !cfg_we_i) |=> (cnt_q == $past(n_eff)))
    else $error("output count not loaded with check item count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n_eff)
    else $error("output count exceeds check item count");

  a_steps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= n_eff)
    else $error("build step count exceeds generator degree");
`endif

endmodule

`default_nettype wire

@@ hdl/rse_cell.sv @@
// rse_cell: one stage of the encoder chain, holding a generator coefficient,
// a remainder byte and an output byte; depends on rse_pkg
`default_nettype none

module rse_cell import rse_pkg::*; (
  input  wire logic             clk_i,
  input  wire ctrl_t            ctrl_i,
  input  wire logic [ByteW-1:0] gen_init_i,
  input  wire logic [ByteW-1:0] mul_b_i,
  input  wire logic [ByteW-1:0] gen_prev_i,
  input  wire logic [ByteW-1:0] rem_prev_i,
  input  wire logic [ByteW-1:0] out_prev_i,
  output logic      [ByteW-1:0] gen_o,
  output logic      [ByteW-1:0] rem_o,
  output logic      [ByteW-1:0] out_o
);

  logic [ByteW-1:0] gen_q, gen_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [ByteW-1:0] out_q, out_d;
  logic [ByteW-1:0] prod;
  logic [ByteW-1:0] rem_next;

  assign prod     = gf_mul(gen_q, mul_b_i);
  assign rem_next = rem_prev_i ^ prod;

  always_comb begin
    gen_d = gen_q;
    rem_d = rem_q;
    out_d = out_q;
    if (ctrl_i.init) begin
      gen_d = gen_init_i;
    end else if (ctrl_i.build) begin
      gen_d = gen_prev_i ^ prod;
    end
    if (ctrl_i.init || ctrl_i.load) begin
      rem_d = '0;
    end else if (ctrl_i.shift) begin
      rem_d = rem_next;
    end
    if (ctrl_i.load) begin
      out_d = rem_next;
    end else if (ctrl_i.pop) begin
      out_d = out_prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q <= gen_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign gen_o = gen_q;
  assign rem_o = rem_q;
  assign out_o = out_q;

endmodule

`default_nettype wire
